/* rtl/ladrc_pkg.sv */
// Package with shared types, constants and fixed-point helpers for the ADRC controller.
`timescale 1ns / 1ps
package ladrc_pkg;

	typedef struct packed {
		logic signed [31:0] setpoint;
		logic signed [31:0] measured;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               clamped;
	} out_beat_t;

	localparam logic [2:0] REG_TRACKER_SPEED = 3'd0;
	localparam logic [2:0] REG_TRACKER_STEP  = 3'd1;
	localparam logic [2:0] REG_OBS_BW        = 3'd2;
	localparam logic [2:0] REG_PLANT_GAIN    = 3'd3;
	localparam logic [2:0] REG_PROP_GAIN     = 3'd4;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd5;
	localparam logic [2:0] REG_DRIVE_LIMIT   = 3'd6;
	localparam logic [2:0] REG_OBS_STEP      = 3'd7;

	localparam logic signed [32:0] LEAK_Q16 = 33'sd64881;

	// Multiplier operand select codes.
	typedef enum logic [3:0] {
		MA_RATE, MA_R, MA_RR, MA_ACC, MA_WC, MA_B0, MA_OBSACC, MA_WC2,
		MA_WC2E, MA_DIST, MA_KP, MA_KD, MA_ZERO
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TD0, ST_TD1, ST_TD2, ST_TD3, ST_TD4, ST_TD5,
		ST_EO0, ST_EO1, ST_EO2, ST_EO3, ST_EO4, ST_EO5, ST_EO6,
		ST_PD0, ST_PD1, ST_PD2, ST_DIV, ST_CLAMP, ST_OUT
	} state_t;

	typedef struct packed {
		state_t step;
		logic   load;
		logic   div_start;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

/* rtl/linear_adrc_controller.sv */
// Top level of the linear active disturbance rejection controller.
`timescale 1ns / 1ps
// Usage: each input beat (setpoint, measured, signed Q16.16) is one control tick.
// The block runs a tracking differentiator, an extended state observer with one
// fresh-error update and a leaking disturbance estimate, then a PD law divided
// by the plant gain and clamped to the drive limit.
// A beat runs through 16 sequencer steps around the one shared multiplier,
// then the bit-serial divider (48 quotient bits, then its done strobe) and
// the clamp. No beat is taken while the previous one is in progress; the
// next beat is accepted on the same edge that delivers the result. The
// result register holds drive and clamped steady under a receiver stall, and no
// new beat is taken meanwhile. Reset clears the state estimates and restores the
// configuration reset values. The user must write configuration only while idle
// (cfg_we/cfg_index/cfg_data); the block itself does not enforce this.
module linear_adrc_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ladrc_pkg::in_beat_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ladrc_pkg::out_beat_t  out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [30:0]           cfg_data
);
	import ladrc_pkg::*;

	logic [30:0] r_q, wc_q, b0_q, kp_q, kd_q, lim_q;
	logic [16:0] h_q, oh_q;
	cmd_t        cmd;
	status_t     status;

	// Configuration registers; index values follow the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= 31'd6553600; h_q <= 17'd66; wc_q <= 31'd1310720;
			b0_q <= 31'd65536; kp_q <= '0; kd_q <= '0; lim_q <= '0; oh_q <= 17'd66;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRACKER_SPEED: r_q   <= cfg_data;
				REG_TRACKER_STEP:  h_q   <= cfg_data[16:0];
				REG_OBS_BW:        wc_q  <= cfg_data;
				REG_PLANT_GAIN:    b0_q  <= cfg_data;
				REG_PROP_GAIN:     kp_q  <= cfg_data;
				REG_DERIV_GAIN:    kd_q  <= cfg_data;
				REG_DRIVE_LIMIT:   lim_q <= cfg_data;
				REG_OBS_STEP:      oh_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	ladrc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	ladrc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_beat(in_data),
		.r_cfg(r_q), .h_cfg(h_q), .wc_cfg(wc_q), .b0_cfg(b0_q), .kp_cfg(kp_q),
		.kd_cfg(kd_q), .lim_cfg(lim_q), .oh_cfg(oh_q), .status(status), .result(out_data)
	);
endmodule

/* rtl/ladrc_div.sv */
// Restoring divider: signed 32-bit numerator by unsigned 31-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module ladrc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic [30:0]        den,
	output logic               done,
	output logic signed [31:0] quot
);
	import ladrc_pkg::*;

	logic [47:0] dividend_q;
	logic [47:0] q_q;
	logic [31:0] rem_q;
	logic [30:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [31:0] rem_sh;
	logic [31:0] rem_sub;
	logic signed [49:0] sq;

	assign rem_sh  = {rem_q[30:0], dividend_q[47]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q      <= num[31];
			dividend_q <= {(num[31] ? 32'(-$signed({num[31], num})) : 32'(num)), 16'h0};
			den_q      <= (den == '0) ? 31'd1 : den;
			rem_q      <= '0;
			q_q        <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[46:0], 1'b0};
			if (!rem_sub[31]) begin
				rem_q <= rem_sub;
				q_q   <= {q_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign sq   = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
	assign quot = sat32(66'(sq));
endmodule

/* rtl/ladrc_datapath.sv */
// Datapath: state registers, one shared multiplier, saturating adders and the divider.
`timescale 1ns / 1ps
module ladrc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ladrc_pkg::cmd_t     cmd,
	input  ladrc_pkg::in_beat_t in_beat,
	input  logic [30:0]         r_cfg,
	input  logic [16:0]         h_cfg,
	input  logic [30:0]         wc_cfg,
	input  logic [30:0]         b0_cfg,
	input  logic [30:0]         kp_cfg,
	input  logic [30:0]         kd_cfg,
	input  logic [30:0]         lim_cfg,
	input  logic [16:0]         oh_cfg,
	output ladrc_pkg::status_t  status,
	output ladrc_pkg::out_beat_t result
);
	import ladrc_pkg::*;

	logic signed [31:0] zp_q, zr_q, xo_q, xd_q, pd_q;
	logic signed [31:0] sp_q, meas_q, err_q, acc_q, t_q, rr_q, wc2_q, u_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic signed [31:0] mq;
	logic signed [31:0] quot;
	logic signed [32:0] b0_eff;
	logic signed [32:0] lim_s;

	assign b0_eff = (b0_cfg == '0) ? 33'sd1 : $signed({2'b00, b0_cfg});
	assign lim_s  = $signed({2'b00, lim_cfg});

	function automatic logic signed [31:0] addq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] subq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(66'(a) - 66'(b));
	endfunction

	function automatic logic signed [31:0] dbl(input logic signed [31:0] a);
		return sat32(66'(a) * 66'sd2);
	endfunction

	// Operand selection for the shared multiplier.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.step)
			ST_TD0: begin ma = 33'(zr_q); mb = $signed({16'h0, h_cfg}); end
			ST_TD1: begin ma = $signed({2'b00, r_cfg}); mb = 33'(zr_q); end
			ST_TD2: begin ma = $signed({2'b00, r_cfg}); mb = $signed({2'b00, r_cfg}); end
			ST_TD3: begin ma = 33'(rr_q); mb = 33'(subq(zp_q, sp_q)); end
			ST_TD4: begin ma = 33'(acc_q); mb = $signed({16'h0, h_cfg}); end
			ST_EO0: begin ma = $signed({2'b00, wc_cfg}); mb = $signed({2'b00, wc_cfg}); end
			ST_EO1: begin ma = $signed({2'b00, wc_cfg}); mb = 33'(err_q); end
			ST_EO2: begin ma = b0_eff; mb = 33'(pd_q); end
			ST_EO3: begin ma = 33'(acc_q); mb = $signed({16'h0, oh_cfg}); end
			ST_EO4: begin ma = 33'(wc2_q); mb = 33'(err_q); end
			ST_EO5: begin ma = 33'(t_q); mb = $signed({16'h0, oh_cfg}); end
			ST_EO6: begin ma = 33'(xd_q); mb = LEAK_Q16; end
			ST_PD0: begin ma = $signed({2'b00, kp_cfg}); mb = 33'(subq(zp_q, xo_q)); end
			ST_PD1: begin ma = $signed({2'b00, kd_cfg}); mb = 33'(zr_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// Floor shift of the 66-bit product equals rounding toward minus infinity.
	assign prod = 66'(ma) * 66'(mb);
	assign mq   = sat32(prod >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zp_q <= '0; zr_q <= '0; xo_q <= '0; xd_q <= '0; pd_q <= '0;
		end else begin
			unique case (cmd.step)
				ST_TD0: zp_q <= addq(zp_q, mq);
				ST_TD5: zr_q <= addq(zr_q, t_q);
				ST_EO3: xo_q <= addq(xo_q, mq);
				ST_EO5: xd_q <= addq(xd_q, mq);
				ST_EO6: xd_q <= mq;
				ST_OUT: pd_q <= result.drive;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sp_q   <= in_beat.setpoint;
			meas_q <= in_beat.measured;
		end
		unique case (cmd.step)
			ST_TD1: acc_q <= sat32(66'sd0 - 66'(mq) * 66'sd2);
			ST_TD2: rr_q  <= mq;
			ST_TD3: acc_q <= subq(acc_q, mq);
			ST_TD4: t_q   <= mq;
			ST_EO0: begin wc2_q <= mq; err_q <= subq(meas_q, xo_q); end
			ST_EO1: acc_q <= addq(xd_q, dbl(mq));
			ST_EO2: acc_q <= addq(acc_q, mq);
			ST_EO4: t_q   <= mq;
			ST_PD0: u_q   <= mq;
			ST_PD1: u_q   <= addq(u_q, mq);
			ST_DIV: if (status.div_done) t_q <= quot;
			ST_CLAMP: begin
				if (33'(t_q) > lim_s) begin
					result.drive <= lim_s[31:0]; result.clamped <= 1'b1;
				end else if (33'(t_q) < -lim_s) begin
					result.drive <= 32'(-lim_s); result.clamped <= 1'b1;
				end else begin
					result.drive <= t_q; result.clamped <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// The numerator is formed from settled terms and captured by the divider at its start.
	ladrc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(subq(u_q, xd_q)),
		.den(b0_cfg), .done(status.div_done), .quot(quot)
	);
endmodule

/* rtl/ladrc_ctrl.sv */
// Controller: sequences one tick through the datapath and runs the handshakes.
`timescale 1ns / 1ps
module ladrc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ladrc_pkg::status_t status,
	output ladrc_pkg::cmd_t    cmd
);
	import ladrc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_TD0;
			ST_TD0: state_d = ST_TD1;
			ST_TD1: state_d = ST_TD2;
			ST_TD2: state_d = ST_TD3;
			ST_TD3: state_d = ST_TD4;
			ST_TD4: state_d = ST_TD5;
			ST_TD5: state_d = ST_EO0;
			ST_EO0: state_d = ST_EO1;
			ST_EO1: state_d = ST_EO2;
			ST_EO2: state_d = ST_EO3;
			ST_EO3: state_d = ST_EO4;
			ST_EO4: state_d = ST_EO5;
			ST_EO5: state_d = ST_EO6;
			ST_EO6: state_d = ST_PD0;
			ST_PD0: state_d = ST_PD1;
			ST_PD1: state_d = ST_PD2;
			ST_PD2: state_d = ST_DIV;
			ST_DIV: if (status.div_done) state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = in_valid ? ST_TD0 : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.step      = state_q;
		in_stall      = !(state_q == ST_IDLE || (state_q == ST_OUT && !out_stall));
		cmd.load      = in_valid && !in_stall;
		cmd.div_start = (state_q == ST_PD2);
		out_valid     = (state_q == ST_OUT);
	end
endmodule

/* rtl/ladrc_checker.sv */
// Port-level checker for the ADRC controller and its bind.
`timescale 1ns / 1ps
module ladrc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input ladrc_pkg::out_beat_t out_data
);
	import ladrc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result waits");
	a_accept_no_quick_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too soon after accept");
	a_clamp_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.clamped && out_data.drive[31] |-> out_data.drive != 32'h80000000)
		else $error("unclamped drive at most negative value");
endmodule

bind linear_adrc_controller ladrc_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
